// ----- src/rdf_pkg.sv -----
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared widths, codes and helpers for the run-length delta frame decoder.
// ----------------------------------------------------------------------------
package rdf_pkg;

	localparam int CELLS_W    = 15;      // cells_in_frame register width
	localparam int MODE_W     = 2;       // pixel format register width
	localparam int CFG_W      = 15;      // widest register
	localparam int MAX_CELLS  = 16384;
	localparam int STORE_AW   = 16;      // frame store address width
	localparam int STORE_DEPTH = 1 << STORE_AW;
	localparam int POS_W      = STORE_AW + 1;  // byte position, holds the depth itself
	localparam int BYTE_W     = 8;

	localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
	localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;

	// configuration register indexes
	localparam logic REG_CELLS = 1'b0;
	localparam logic REG_MODE  = 1'b1;

	// operation codes
	localparam logic OP_RUN  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// color modes
	localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PAL1 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAL2 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RGB  = 2'd3;

	// log2 of bytes per cell
	function automatic logic [1:0] cell_shift(input logic [MODE_W-1:0] mode);
		logic [1:0] sh;
		case (mode)
			MODE_MONO: sh = 2'd0;
			MODE_PAL1: sh = 2'd1;
			MODE_PAL2: sh = 2'd1;
			MODE_RGB:  sh = 2'd2;
			default:   sh = 2'd0;
		endcase
		return sh;
	endfunction

	// bytes in one frame, cells saturated at MAX_CELLS
	function automatic logic [POS_W-1:0] frame_bytes(input logic [CELLS_W-1:0] cells,
		input logic [MODE_W-1:0] mode);
		logic [POS_W-1:0] c;
		if (cells > CELLS_W'(MAX_CELLS)) c = POS_W'(MAX_CELLS);
		else c = POS_W'(cells);
		return c << cell_shift(mode);
	endfunction

endpackage

// ----- src/rle_delta_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_delta_frame_decoder
// Expands run-length pairs into a 64 KiB frame store with key/delta update.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that fills the frame store
// with space bytes; no item is taken during it (configuration writes still
// are). A decode item (operation 0) goes through ST_SETUP and ST_RUN, on the
// last pair of a frame also ST_PAD, and then ST_DONE. It decodes one byte
// per cycle, whether the byte is written or kept: the run's bytes, and on
// the last pair of a frame the zero padding up to the frame end. The frame
// store has a single write port. A read item (operation 1) passes through
// ST_RD, where the registered read of the store fetches its byte, and then
// ST_DONE. ST_DONE loads the result once the result register is free, and
// the block returns to idle, ready for the next item, on that same edge.
// Every item gives exactly one result; the result register lets the next
// item enter while a finished result still waits.
module rle_delta_frame_decoder
	import rdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // run_count[7:0], run_value[15:8], read_address[31:16]
	input  logic [1:0]  s_tuser,    // operation[0], key_frame[1]
	input  logic        s_tlast,    // last_pair
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // read_data[7:0], run_clamped[8], zero[15:9]
	output logic        m_tlast     // frame_done
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_PAD,
		ST_RD,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [CELLS_W-1:0] cells_q;
	logic [MODE_W-1:0]  mode_q;

	// frame state
	logic [POS_W-1:0]    wp_q;
	logic [1:0]          off_q;
	logic                kept_q;
	logic                key_q;
	logic                started_q;
	logic [STORE_AW-1:0] clr_q;

	// item in flight
	logic [BYTE_W-1:0]   cnt_q;
	logic [BYTE_W-1:0]   value_q;
	logic                last_q;
	logic                clamped_q;
	logic                is_read_q;
	logic [STORE_AW-1:0] raddr_q;

	// result register
	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;
	logic                m_tlast_q;

	// frame store
	logic [BYTE_W-1:0]   mem [STORE_DEPTH];
	logic [BYTE_W-1:0]   rd_q;
	logic                mem_we;
	logic [STORE_AW-1:0] mem_waddr;
	logic [BYTE_W-1:0]   mem_wdata;

	logic                accept;
	logic [POS_W-1:0]    total;
	logic [2:0]          cell_bytes;
	logic                room;
	logic [BYTE_W-1:0]   put_val;
	logic                put_active;
	logic                kept_new;
	logic                put_we;
	logic [1:0]          off_next;
	logic                load_res;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// frame length follows the current registers
	assign total      = frame_bytes(cells_q, mode_q);
	assign cell_bytes = 3'd1 << cell_shift(mode_q);
	assign room       = (wp_q < total);

	// one byte per cycle: run value while counting, zeros while padding
	assign put_val    = (state_q == ST_PAD) ? ZERO_BYTE : value_q;
	assign put_active = room && (((state_q == ST_RUN) && (cnt_q != '0)) || (state_q == ST_PAD));
	// a delta cell is kept whole when its first byte decodes to zero
	assign kept_new   = (off_q == 2'd0) ? (put_val == ZERO_BYTE) : kept_q;
	assign put_we     = key_q || !kept_new;
	assign off_next   = (({1'b0, off_q} + 3'd1) >= cell_bytes) ? 2'd0 : (off_q + 2'd1);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = SPACE_BYTE;
		end else begin
			mem_we    = put_active && put_we;
			mem_waddr = wp_q[STORE_AW-1:0];
			mem_wdata = put_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[raddr_q];
	end

	// take the finished result once the result register is free
	assign load_res = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= CELLS_W'(1920);
			mode_q  <= MODE_MONO;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CELLS: cells_q <= cfg_wdata[CELLS_W-1:0];
				REG_MODE:  mode_q  <= cfg_wdata[MODE_W-1:0];
				default:   ;
			endcase
		end
	end

	// payload of the item in flight and of the result
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= s_tdata[15:8];
			raddr_q <= s_tdata[31:16];
		end
		if (load_res) begin
			m_tdata_q <= {7'd0, clamped_q, (is_read_q ? rd_q : ZERO_BYTE)};
			m_tlast_q <= last_q && !is_read_q;
		end
	end

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			wp_q       <= '0;
			off_q      <= 2'd0;
			kept_q     <= 1'b0;
			key_q      <= 1'b0;
			started_q  <= 1'b0;
			cnt_q      <= '0;
			last_q     <= 1'b0;
			clamped_q  <= 1'b0;
			is_read_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (put_active) begin
				wp_q   <= wp_q + POS_W'(1);
				off_q  <= off_next;
				kept_q <= kept_new;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + STORE_AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cnt_q     <= s_tdata[7:0];
						last_q    <= s_tlast;
						clamped_q <= 1'b0;
						if (s_tuser[0] == OP_READ) begin
							is_read_q <= 1'b1;
							state_q   <= ST_RD;
						end else begin
							is_read_q <= 1'b0;
							state_q   <= ST_SETUP;
							// first pair of a frame: latch the kind, restart position
							if (!started_q) begin
								started_q <= 1'b1;
								key_q     <= s_tuser[1];
								wp_q      <= '0;
								off_q     <= 2'd0;
								kept_q    <= 1'b0;
							end
						end
					end
				end
				ST_SETUP: begin
					// a full frame flags the pair, even with a zero count
					clamped_q <= !room;
					state_q   <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q != '0) begin
						if (room) begin
							cnt_q <= cnt_q - BYTE_W'(1);
						end else begin
							clamped_q <= 1'b1;
							cnt_q     <= '0;
						end
					end else begin
						state_q <= last_q ? ST_PAD : ST_DONE;
					end
				end
				ST_PAD: begin
					if (!room) begin
						started_q <= 1'b0;
						state_q   <= ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the byte position never passes the store size
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= POS_W'(STORE_DEPTH))
		else $error("write position beyond frame store");

	// a result enters the output register only from the finishing state
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the finishing state");

	// decode writes land only inside the current frame
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |-> (started_q && room))
		else $error("frame store written outside an open frame");

	// a read item keeps the store untouched while its data is fetched
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> !mem_we)
		else $error("frame store written during a read");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length delta frame decoder: drives run
// pairs and store reads over the stream ports, predicts every result from a
// private image of the frame store, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rdf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// no item may stall this long; covers the clearing pass after reset plus a
	// full 64 KiB padding pass and the long receiver hold, several times over
	localparam int WATCHDOG_LIMIT = 300000;
	localparam int MAX_REPORTS    = 10;
	localparam int TAIL_CYCLES    = 16;

	typedef struct packed {
		logic        op;
		logic        key;
		logic [7:0]  count;
		logic [7:0]  value;
		logic        last;
		logic [15:0] raddr;
	} pair_item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       done;
		logic       clamped;
	} frame_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // run_count[7:0], run_value[15:8], read_address[31:16]
	logic [1:0]        s_tuser;   // operation[0], key_frame[1]
	logic              s_tlast;   // last_pair
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // read_data[7:0], run_clamped[8], zero[15:9]
	logic              m_tlast;   // frame_done

	rle_delta_frame_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// ------------------------------------------------------------------
	// Frame store image and decoder state, kept in step with accepted items
	// ------------------------------------------------------------------
	logic [7:0]        store_image [0:STORE_DEPTH-1];
	int unsigned       pos;        // bytes produced in the current frame
	int unsigned       cell_off;   // byte index inside the current cell
	bit                kept;       // current delta cell keeps its stored bytes
	bit                is_key;
	bit                in_frame;
	logic [CELLS_W-1:0] cfg_cells;
	logic [MODE_W-1:0]  cfg_mode;

	frame_result_t     owed_results [$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold_request = 0;
	int idle_cycles = 0;
	int fail_count = 0;
	int items_sent = 0;
	int pairs_sent = 0;
	int reads_sent = 0;
	int frames_closed = 0;
	int runs_clamped = 0;

	function automatic int unsigned cell_bytes(input logic [MODE_W-1:0] m);
		case (m)
			MODE_MONO:            return 1;
			MODE_PAL1, MODE_PAL2: return 2;
			default:              return 4;
		endcase
	endfunction

	// frame length in bytes for the current settings, cells and bytes saturated
	function automatic int unsigned frame_len();
		int unsigned c;
		c = (cfg_cells > MAX_CELLS) ? MAX_CELLS : cfg_cells;
		c = c * cell_bytes(cfg_mode);
		return (c > STORE_DEPTH) ? STORE_DEPTH : c;
	endfunction

	// one decoded byte: a delta cell is decided by its first byte
	function automatic void put_store_byte(input logic [7:0] v, input int unsigned s);
		int unsigned a;
		a = pos % STORE_DEPTH;
		if (is_key) begin
			store_image[a] = v;
		end else begin
			if (cell_off == 0) kept = (v == ZERO_BYTE);
			if (!kept) store_image[a] = v;
		end
		pos++;
		cell_off = (cell_off + 1 >= s) ? 0 : ((cell_off + 1) & 3);
	endfunction

	// apply one accepted item to the image and return the result it owes
	function automatic frame_result_t advance_frame(input pair_item_t it);
		frame_result_t r;
		int unsigned total, s, remaining, n, i;
		r = '0;
		if (it.op == OP_READ) begin
			r.rdata = store_image[it.raddr];
			return r;
		end
		if (!in_frame) begin
			in_frame = 1'b1;
			is_key   = it.key;
			pos      = 0;
			cell_off = 0;
			kept     = 1'b0;
		end
		total = frame_len();
		s = cell_bytes(cfg_mode);
		remaining = (pos < total) ? total - pos : 0;
		if (remaining == 0) begin
			r.clamped = 1'b1;
		end else begin
			n = it.count;
			if (n > remaining) begin
				n = remaining;
				r.clamped = 1'b1;
			end
			for (i = 0; i < n; i++) put_store_byte(it.value, s);
		end
		if (it.last) begin
			while (pos < total) put_store_byte(ZERO_BYTE, s);
			in_frame = 1'b0;
			r.done = 1'b1;
		end
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
	endfunction

	// ------------------------------------------------------------------
	// Clock, receiver and result checking
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stall bursts, or a long hold when a test asks for one.
	// The hold is counted here so the sender keeps offering items meanwhile.
	initial begin : rx_side
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request != 0) begin
				stall_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result with the oldest owed one, field by field.
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				note_failure($sformatf("unexpected result data=%h last=%b", m_tdata, m_tlast));
			end else begin
				want = owed_results.pop_front();
				if (m_tdata[7:0] !== want.rdata || m_tdata[8] !== want.clamped ||
				    m_tlast !== want.done) begin
					note_failure($sformatf(
						"expected read_data=%h clamped=%b done=%b, got %h %b %b",
						want.rdata, want.clamped, want.done,
						m_tdata[7:0], m_tdata[8], m_tlast));
				end
				if (want.done) frames_closed++;
				if (want.clamped) runs_clamped++;
			end
		end
	end

	// Watchdog: end the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------

	// Offer one item and hold it until accepted. Valid stays high afterwards
	// so back-to-back items never lower and raise it in the same step.
	task automatic send_item(input pair_item_t it);
		int gap;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.raddr, it.value, it.count};
		s_tuser  <= {it.key, it.op};
		s_tlast  <= it.last;
		do @(posedge clk); while (!s_tready);
		owed_results.insert(owed_results.size(), advance_frame(it));
		items_sent++;
		if (it.op == OP_READ) reads_sent++;
		else pairs_sent++;
	endtask

	task automatic send_pair(input logic key, input logic [7:0] count,
		input logic [7:0] value, input logic last);
		pair_item_t it;
		it.op    = OP_RUN;
		it.key   = key;
		it.count = count;
		it.value = value;
		it.last  = last;
		it.raddr = 16'($urandom);
		send_item(it);
	endtask

	// fill the unused fields of a read with noise; the block must ignore them
	task automatic send_read(input logic [15:0] addr);
		pair_item_t it;
		it.op    = OP_READ;
		it.key   = 1'($urandom);
		it.count = 8'($urandom);
		it.value = 8'($urandom);
		it.last  = 1'($urandom);
		it.raddr = addr;
		send_item(it);
	endtask

	// Drop valid and wait until every owed result is back; the block is idle
	// after that, since every item owes exactly one result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers on consecutive edges, then drop the enable
	task automatic set_format(input logic [CELLS_W-1:0] cells, input logic [MODE_W-1:0] mode);
		cfg_wen   <= 1'b1;
		cfg_index <= REG_CELLS;
		cfg_wdata <= CFG_W'(cells);
		@(posedge clk);
		cfg_index <= REG_MODE;
		cfg_wdata <= CFG_W'(mode);
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_cells = cells;
		cfg_mode  = mode;
		@(posedge clk);
	endtask

	// mostly small frames, a few empty, single-cell or a few hundred cells
	task automatic pick_random_format();
		int unsigned r;
		logic [CELLS_W-1:0] cells;
		r = $urandom_range(0, 15);
		if (r == 0) cells = '0;
		else if (r == 1) cells = CELLS_W'(1);
		else if (r == 2) cells = CELLS_W'($urandom_range(200, 600));
		else cells = CELLS_W'($urandom_range(2, 48));
		set_format(cells, MODE_W'($urandom_range(0, 3)));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// the clearing pass leaves a space in the first, the last and a middle byte
	task automatic test_store_after_reset();
		set_format(CELLS_W'(4), MODE_MONO);
		send_read(16'h0000);
		send_read(16'hFFFF);
		send_read(16'h5A5A);
		drain();
	endtask

	// key frame: overrun cut at the frame end, pairs on a full frame ignored
	task automatic test_key_frame();
		send_pair(1'b1, 8'd3, 8'hFF, 1'b0);
		send_pair(1'b0, 8'd2, 8'h00, 1'b0);
		send_pair(1'b1, 8'd0, 8'h7E, 1'b0);
		send_pair(1'b0, 8'd255, 8'h01, 1'b1);
		send_read(16'd2);
		send_read(16'd3);
		drain();
	endtask

	// delta frame: a zero first byte keeps the stored cell, padding on last
	task automatic test_delta_frame();
		set_format(CELLS_W'(2), MODE_RGB);
		send_pair(1'b0, 8'd4, 8'h00, 1'b0);
		send_pair(1'b1, 8'd3, 8'hA5, 1'b1);
		send_read(16'd0);
		send_read(16'd5);
		send_read(16'd7);
		drain();
	endtask

	// change the format in the middle of a frame: cell offset wraps early,
	// then the frame shrinks below the write position and counts as full
	task automatic test_format_change_mid_frame();
		set_format(CELLS_W'(4), MODE_RGB);
		send_pair(1'b0, 8'd3, 8'h3C, 1'b0);
		drain();
		set_format(CELLS_W'(4), MODE_PAL2);
		send_pair(1'b0, 8'd6, 8'h00, 1'b0);
		drain();
		set_format(CELLS_W'(2), MODE_MONO);
		send_pair(1'b0, 8'd0, 8'h55, 1'b1);
		drain();
	endtask

	// empty frame, then a cell count above the limit that fills the whole store
	task automatic test_frame_size_limits();
		set_format('0, MODE_PAL1);
		send_pair(1'b1, 8'd255, 8'hFF, 1'b1);
		drain();
		set_format(CELLS_W'(32767), MODE_RGB);
		send_pair(1'b1, 8'd255, 8'hFF, 1'b0);
		send_pair(1'b0, 8'd255, 8'h80, 1'b1);
		send_read(16'hFFFF);
		send_read(16'd300);
		send_read(16'd0);
		drain();
	endtask

	// hold the receiver for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		int i;
		set_format(CELLS_W'(40), MODE_PAL1);
		rx_hold_request = 400;
		for (i = 0; i < 24; i++) begin
			if (i % 3 == 0) send_pair(1'($urandom), 8'($urandom_range(0, 6)), 8'($urandom), 1'b0);
			else send_read(16'($urandom_range(0, 95)));
		end
		send_pair(1'b0, 8'd1, 8'h00, 1'b1);
		drain();
	endtask

	// one frame of random pairs with reads mixed in; now and then the frame
	// is left open, or the format changes halfway
	task automatic random_frame();
		int unsigned pairs, span, i, lim;
		logic [7:0] cnt, val;
		logic frame_key, closes;
		pairs = $urandom_range(1, 8);
		frame_key = 1'($urandom);
		closes = ($urandom_range(0, 15) != 0);
		for (i = 0; i < pairs; i++) begin
			if (i != 0 && i == pairs / 2 && $urandom_range(0, 7) == 0) begin
				drain();
				pick_random_format();
			end
			span = frame_len();
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1) == 0) send_read(16'($urandom));
				else send_read(16'($urandom_range(0, span + 7)));
			end
			lim = 2 * span / pairs + 2;
			if (lim > 255) lim = 255;
			if ($urandom_range(0, 4) == 0) cnt = 8'($urandom_range(0, 255));
			else cnt = 8'($urandom_range(0, lim));
			val = ($urandom_range(0, 2) == 0) ? ZERO_BYTE : 8'($urandom);
			send_pair((i == 0) ? frame_key : 1'($urandom), cnt, val,
				closes && (i == pairs - 1));
		end
	endtask

	// random phases, each with its own format; no idling in the final stretch
	task automatic test_random_frames(input int n_items);
		int first_item;
		first_item = items_sent;
		while (items_sent - first_item < n_items) begin
			if (items_sent - first_item >= n_items - 150) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			drain();
			pick_random_format();
			repeat ($urandom_range(2, 6)) random_frame();
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		for (int a = 0; a < STORE_DEPTH; a++) store_image[a] = SPACE_BYTE;
		pos       = 0;
		cell_off  = 0;
		kept      = 1'b0;
		is_key    = 1'b0;
		in_frame  = 1'b0;
		cfg_cells = CELLS_W'(1920);
		cfg_mode  = MODE_MONO;

		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_index = REG_CELLS;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		s_tlast   = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_after_reset();
		test_key_frame();
		test_delta_frame();
		test_format_change_mid_frame();
		test_frame_size_limits();
		test_backpressure();
		test_random_frames(1000);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d run pairs and %0d store reads; %0d frames closed, %0d runs cut",
			pairs_sent, reads_sent, frames_closed, runs_clamped);
		$display("formats from empty to full store, key and delta frames; %0d mismatches",
			fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/rdf_pkg.sv
src/rle_delta_frame_decoder.sv
sim/tb_top.sv
